@@ src/imm_pkg.sv @@
package imm_pkg;

  localparam int unsigned MAX_DIM_DEF = 8;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  localparam logic [CFG_IX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clear;       // zero the accumulator for a new result element
    logic data_valid;  // memory read data holds a valid operand pair
  } mac_ctrl_t;

endpackage

@@ src/imm_ram.sv @@
module imm_ram import imm_pkg::*; #(
  parameter int unsigned DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
  parameter int unsigned WIDTH = VAL_W,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/imm_mac.sv @@
module imm_mac import imm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mac_ctrl_t        ctrl_i,
  input  logic [VAL_W-1:0] a_i,
  input  logic [VAL_W-1:0] b_i,
  output logic [VAL_W-1:0] acc_o,
  output logic             busy_o
);

  logic [VAL_W-1:0] prod_q;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic             prod_vld_q;

  // low half of the product only: everything wraps modulo 2^32
  always_ff @(posedge clk_i) begin
    if (ctrl_i.data_valid) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.data_valid;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

@@ src/imm_ctrl.sv @@
module imm_ctrl import imm_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF,
  localparam int unsigned AW     = $clog2(MAX_DIM * MAX_DIM),
  localparam int unsigned CNT_W  = $clog2(MAX_DIM + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CNT_W-1:0]        nr_i,
  input  logic [CNT_W-1:0]        nk_i,
  input  logic [CNT_W-1:0]        nc_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [IDX_W-1:0]        row_i,
  input  logic [IDX_W-1:0]        col_i,
  output logic                    a_we_o,
  output logic                    b_we_o,
  output logic [AW-1:0]           a_waddr_o,
  output logic [AW-1:0]           b_waddr_o,
  output logic                    rd_en_o,
  output logic [AW-1:0]           a_raddr_o,
  output logic [AW-1:0]           b_raddr_o,
  output mac_ctrl_t               mac_ctrl_o,
  input  logic [VAL_W-1:0]        acc_i,
  input  logic                    mac_busy_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [IDX_W-1:0]        out_row_o,
  output logic [IDX_W-1:0]        out_col_o,
  output logic signed [VAL_W-1:0] product_value_o,
  output logic                    last_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] i_q, j_q, k_q;
  logic             rd_pending_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic [VAL_W-1:0] out_val_q;
  logic             out_last_q;

  logic accept, is_compute, in_range, empty_result;
  logic issue, done, emit_fire, last_elem, start, advance;

  assign accept       = in_valid_i && !in_stall_o;
  assign in_range     = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
  assign empty_result = (nr_i == '0) || (nc_i == '0);
  assign last_elem    = (CNT_W'(i_q + CNT_W'(1)) == nr_i) &&
                        (CNT_W'(j_q + CNT_W'(1)) == nc_i);
  assign emit_fire    = !out_valid_q || !out_stall_i;

  // load decode; loads complete in the accept cycle
  always_comb begin
    a_we_o     = 1'b0;
    b_we_o     = 1'b0;
    is_compute = 1'b0;
    unique case (cmd_e'(command_i))
      CMD_LOAD_A:  a_we_o     = accept && in_range;
      CMD_LOAD_B:  b_we_o     = accept && in_range;
      CMD_COMPUTE: is_compute = 1'b1;
      default: ;
    endcase
  end

  assign a_waddr_o = AW'(AW'(row_i) * AW'(MAX_DIM) + AW'(col_i));
  assign b_waddr_o = AW'(AW'(col_i) * AW'(MAX_DIM) + AW'(row_i));

  // B is held transposed, so both operands walk along a row
  assign a_raddr_o = AW'(AW'(i_q) * AW'(MAX_DIM) + AW'(k_q));
  assign b_raddr_o = AW'(AW'(j_q) * AW'(MAX_DIM) + AW'(k_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_compute && !empty_result) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = last_elem ? ST_IDLE : ST_RUN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    done       = 1'b0;
    start      = 1'b0;
    advance    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        start      = accept && is_compute && !empty_result;
      end
      ST_RUN: begin
        issue = (k_q != nk_i);
        done  = (k_q == nk_i) && !rd_pending_q && !mac_busy_i;
      end
      ST_EMIT: begin
        advance = emit_fire && !last_elem;
      end
      default: ;
    endcase
  end

  assign rd_en_o               = issue;
  assign mac_ctrl_o.clear      = start || advance;
  assign mac_ctrl_o.data_valid = rd_pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      rd_pending_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_pending_q <= issue;
      if (start) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (advance) begin
        k_q <= '0;
        if (CNT_W'(j_q + CNT_W'(1)) == nc_i) begin
          j_q <= '0;
          i_q <= CNT_W'(i_q + CNT_W'(1));
        end else begin
          j_q <= CNT_W'(j_q + CNT_W'(1));
        end
      end else if (issue) begin
        k_q <= CNT_W'(k_q + CNT_W'(1));
      end
      if (state_q == ST_EMIT && emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && emit_fire) begin
      out_row_q  <= IDX_W'(i_q);
      out_col_q  <= IDX_W'(j_q);
      out_val_q  <= acc_i;
      out_last_q <= last_elem;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = signed'(out_val_q);
  assign last_o          = out_last_q;

`ifndef NO_ASSERTIONS
  a_drained_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!rd_pending_q && !mac_busy_i))
    else $error("result emitted before the multiply-accumulate pipe drained");

  a_issue_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> ((i_q < nr_i) && (j_q < nc_i) && (k_q < nk_i)))
    else $error("operand read outside the configured dimensions");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && emit_fire && last_elem) |=>
      (state_q == ST_IDLE && out_valid_q && out_last_q))
    else $error("final element did not end the compute run");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_we_o || b_we_o) |-> (state_q == ST_IDLE && !rd_pending_q && !mac_busy_i))
    else $error("matrix write during a compute run");
`endif

endmodule

@@ src/integer_matrix_multiply.sv @@
// Integer matrix multiply. Load requests (command 0 for A, 1 for B) write one
// element each; a load whose row or col is not below MAX_DIM is dropped. A
// compute request emits rows_a x cols_b results in row-major order, last_o
// set on the final one. The two matrix memories each have one read port, so
// the dot product takes one term per cycle through a registered multiplier
// and accumulator, then waits for the pipeline to drain and passes through
// the output register. New requests are held off (in_stall_o high) until the
// last result of a compute has been placed in the output register. Products
// and sums wrap modulo 2^32. Dimension registers above MAX_DIM act as
// MAX_DIM; rows_a or cols_b of zero makes a compute emit nothing.
// Configuration writes are expected only while the block is idle. Memories
// come out of reset undefined: compute only over elements already loaded.
module integer_matrix_multiply import imm_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [IDX_W-1:0]        row_i,
  input  logic [IDX_W-1:0]        col_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [IDX_W-1:0]        out_row_o,
  output logic [IDX_W-1:0]        out_col_o,
  output logic signed [VAL_W-1:0] product_value_o,
  output logic                    last_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [CNT_W-1:0] nr, nk, nc;

  logic             a_we, b_we, rd_en;
  logic [AW-1:0]    a_waddr, b_waddr, a_raddr, b_raddr;
  logic [VAL_W-1:0] a_rdata, b_rdata, acc;
  logic             mac_busy;
  mac_ctrl_t        mac_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CFG_W'(8);
      inner_dim_q <= CFG_W'(8);
      cols_b_q    <= CFG_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturate to the storage size
  assign nr = (32'(rows_a_q) > MAX_DIM)    ? CNT_W'(MAX_DIM) : CNT_W'(rows_a_q);
  assign nk = (32'(inner_dim_q) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(inner_dim_q);
  assign nc = (32'(cols_b_q) > MAX_DIM)    ? CNT_W'(MAX_DIM) : CNT_W'(cols_b_q);

  imm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .nr_i            (nr),
    .nk_i            (nk),
    .nc_i            (nc),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .a_we_o          (a_we),
    .b_we_o          (b_we),
    .a_waddr_o       (a_waddr),
    .b_waddr_o       (b_waddr),
    .rd_en_o         (rd_en),
    .a_raddr_o       (a_raddr),
    .b_raddr_o       (b_raddr),
    .mac_ctrl_o      (mac_ctrl),
    .acc_i           (acc),
    .mac_busy_i      (mac_busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

  imm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VAL_W)
  ) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (unsigned'(value_i)),
    .re_i    (rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  imm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VAL_W)
  ) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (unsigned'(value_i)),
    .re_i    (rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  imm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (a_rdata),
    .b_i    (b_rdata),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

endmodule

@@ verif/tb_integer_matrix_multiply.sv @@
module tb_integer_matrix_multiply;
  import imm_pkg::*;

  localparam int unsigned DIM          = MAX_DIM_DEF;
  localparam int unsigned DRAIN_CYCLES = 3 * (DIM + 4);
  localparam int unsigned ITEMS_TARGET = 260;
  localparam int unsigned LONG_HOLD    = 300;
  localparam longint      TIMEOUT      = 64'd150_000_000;

  // codes the package does not name
  localparam logic [CMD_W-1:0]    CMD_UNUSED = 2'd3;
  localparam logic [CFG_IX_W-1:0] REG_NONE   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
  } product_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IX_W-1:0]     cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        command_i   = '0;
  logic [IDX_W-1:0]        row_i       = '0;
  logic [IDX_W-1:0]        col_i       = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [IDX_W-1:0]        out_row_o;
  logic [IDX_W-1:0]        out_col_o;
  logic signed [VAL_W-1:0] product_value_o;
  logic                    last_o;

  integer_matrix_multiply dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

  always #10 clk_i = ~clk_i;

  request_t pending_reqs[$];
  product_t product_q[$];

  // predictor state
  logic [VAL_W-1:0] mat_a  [DIM*DIM];
  logic [VAL_W-1:0] mat_bt [DIM*DIM];
  logic [CFG_W-1:0] dim_rows  = CFG_W'(8);
  logic [CFG_W-1:0] dim_inner = CFG_W'(8);
  logic [CFG_W-1:0] dim_cols  = CFG_W'(8);

  // which elements the queued loads will have written
  bit a_loaded [DIM*DIM];
  bit b_loaded [DIM*DIM];

  int  n_items    = 0;
  int  n_computes = 0;
  int  n_results  = 0;
  int  n_errors   = 0;
  int  n_phases   = 0;
  bit  steady     = 1'b0;
  bit  in_taken   = 1'b0;
  int  gap_left   = 0;
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  request_t drv_req;

  function automatic int eff_dim(logic [CFG_W-1:0] v);
    return (v > DIM) ? DIM : int'(v);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 32'h8000_0000;
    if (r < 16) return 32'h7fff_ffff;
    if (r < 24) return 32'hffff_ffff;
    if (r < 28) return 32'h0;
    if (r < 50) return VAL_W'($signed($urandom_range(0, 40)) - 20);
    return $urandom;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return CFG_W'(0);
    if (r < 18) return CFG_W'($urandom_range(9, 15));
    if (r < 28) return CFG_W'(8);
    return CFG_W'($urandom_range(1, 4));
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // predictor update for one accepted request: loads write the model matrices, a compute queues its expected products
  task automatic apply_request(request_t req);
    int nr, nk, nc;
    logic [VAL_W-1:0] acc;
    product_t p;
    nr = eff_dim(dim_rows);
    nk = eff_dim(dim_inner);
    nc = eff_dim(dim_cols);
    if (req.cmd == CMD_LOAD_A) begin
      mat_a[req.row * DIM + req.col] = req.value;
    end else if (req.cmd == CMD_LOAD_B) begin
      mat_bt[req.col * DIM + req.row] = req.value;
    end else if (req.cmd == CMD_COMPUTE) begin
      n_computes++;
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          acc = '0;
          for (int k = 0; k < nk; k++) acc += mat_a[i * DIM + k] * mat_bt[j * DIM + k];
          p.row   = IDX_W'(i);
          p.col   = IDX_W'(j);
          p.value = acc;
          p.last  = (i == nr - 1) && (j == nc - 1);
          product_q.push_back(p);
        end
      end
    end
  endtask

  task automatic check_product(product_t got);
    product_t want;
    n_results++;
    if (product_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result (%0d,%0d) value %0d last %0b",
                                got.row, got.col, $signed(got.value), got.last));
    end else begin
      want = product_q.pop_front();
      if (got !== want)
        report_mismatch($sformatf("result (%0d,%0d) %0d last %0b, expected (%0d,%0d) %0d last %0b",
                                  got.row, got.col, $signed(got.value), got.last,
                                  want.row, want.col, $signed(want.value), want.last));
    end
  endtask

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i)
        check_product('{out_row_o, out_col_o, product_value_o, last_o});
      if (in_valid_i && !in_stall_o)
        apply_request('{command_i, row_i, col_i, value_i});
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        drv_req    = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        command_i  <= drv_req.cmd;
        row_i      <= drv_req.row;
        col_i      <= drv_req.col;
        value_i    <= drv_req.value;
        gap_left   <= (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver; one long hold while requests are still being offered
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && n_results >= 60 && in_valid_i && product_q.size() > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= LONG_HOLD;
        hold_done   <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= idle_len() - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_req(logic [CMD_W-1:0] cmd, int row, int col,
                          logic [VAL_W-1:0] value);
    logic [IDX_W-1:0] r, c;
    r = IDX_W'(row);
    c = IDX_W'(col);
    pending_reqs.push_back('{cmd, r, c, value});
    if (cmd == CMD_LOAD_A) a_loaded[r * DIM + c] = 1'b1;
    if (cmd == CMD_LOAD_B) b_loaded[c * DIM + r] = 1'b1;
    if (cmd != CMD_UNUSED) n_items++;
  endtask

  // some random loads and unused commands, then whatever the product still lacks, then compute
  task automatic queue_multiply(int extra);
    int nr, nk, nc;
    nr = eff_dim(dim_rows);
    nk = (eff_dim(dim_inner) == 0) ? 1 : eff_dim(dim_inner);
    nc = eff_dim(dim_cols);
    repeat (extra) begin
      if ($urandom_range(0, 5) == 0)
        push_req(CMD_UNUSED, $urandom, $urandom, $urandom);
      else
        push_req($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                 $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1), pick_value());
    end
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (nc > 0 && !a_loaded[i * DIM + k]) push_req(CMD_LOAD_A, i, k, pick_value());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (nr > 0 && !b_loaded[j * DIM + k]) push_req(CMD_LOAD_B, k, j, pick_value());
    push_req(CMD_COMPUTE, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || product_q.size() != 0)
      @(posedge clk_i);
    // a trailing load may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ROWS_A;
    cfg_data_i  <= r;
    @(negedge clk_i);
    cfg_index_i <= REG_INNER_DIM;
    cfg_data_i  <= k;
    @(negedge clk_i);
    cfg_index_i <= REG_COLS_B;
    cfg_data_i  <= c;
    @(negedge clk_i);
    cfg_index_i <= REG_NONE;
    cfg_data_i  <= CFG_W'($urandom);
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    dim_rows  = r;
    dim_inner = k;
    dim_cols  = c;
    steady    = ($urandom_range(0, 4) == 0);
    n_phases++;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset dimensions: fill both matrices, multiply twice
    queue_multiply(2);
    queue_multiply(5);

    // 1x1: wrap of the square of the largest value, then most negative times -1
    set_dims(CFG_W'(1), CFG_W'(1), CFG_W'(1));
    push_req(CMD_LOAD_A, 0, 0, 32'h7fff_ffff);
    push_req(CMD_LOAD_B, 0, 0, 32'h7fff_ffff);
    push_req(CMD_COMPUTE, 0, 0, 32'h0);
    push_req(CMD_LOAD_A, 0, 0, 32'h8000_0000);
    push_req(CMD_LOAD_B, 0, 0, 32'hffff_ffff);
    push_req(CMD_UNUSED, 7, 7, 32'hffff_ffff);
    push_req(CMD_LOAD_A, 7, 7, 32'hffff_ffff);
    push_req(CMD_LOAD_B, 7, 7, 32'h0);
    push_req(CMD_UNUSED, 0, 0, 32'h0);
    push_req(CMD_COMPUTE, 7, 7, 32'hffff_ffff);

    // zero rows, zero inner, zero cols
    set_dims(CFG_W'(0), CFG_W'(3), CFG_W'(3));
    queue_multiply(1);
    set_dims(CFG_W'(2), CFG_W'(0), CFG_W'(2));
    queue_multiply(1);
    set_dims(CFG_W'(3), CFG_W'(2), CFG_W'(0));
    queue_multiply(1);
    // registers above the maximum saturate
    set_dims(CFG_W'(15), CFG_W'(9), CFG_W'(12));
    queue_multiply(2);
    queue_multiply(2);

    while (n_items < ITEMS_TARGET) begin
      set_dims(pick_dim(), pick_dim(), pick_dim());
      repeat ($urandom_range(1, 3)) queue_multiply($urandom_range(0, 8));
    end

    wait_idle();
    $display("Covered %0d requests (%0d computes) over %0d dimension settings,",
             n_items, n_computes, n_phases);
    $display("checked %0d product elements, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("** integer_matrix_multiply: PASSED **");
    end else begin
      $display("** integer_matrix_multiply: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("Timed out with %0d results outstanding", product_q.size());
    $display("** integer_matrix_multiply: FAILED **");
    $finish;
  end

endmodule

@@ integer_matrix_multiply.f @@
src/imm_pkg.sv
src/imm_ram.sv
src/imm_mac.sv
src/imm_ctrl.sv
src/integer_matrix_multiply.sv
verif/tb_integer_matrix_multiply.sv
